>>> src/dotted_oid_to_ber_bytes_unit_macros.svh
// Assertion macros for the dotted OID to BER byte encoder.
// Used by the port checker; needs clk and rst_n in the including scope.
`ifndef DOTTED_OID_TO_BER_BYTES_UNIT_MACROS_SVH
`define DOTTED_OID_TO_BER_BYTES_UNIT_MACROS_SVH

// A condition that must hold in the same cycle as its trigger.
`define OIDBER_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// A condition that must hold in the cycle after its trigger.
`define OIDBER_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/oidber_pkg.sv
// Shared types and constants for the dotted OID to BER byte encoder.
// No dependencies; used by the top level and its port checker.
package oidber_pkg;

  // Width in bits of the widest decimal arc that is accepted.
  localparam int ARC_BITS = 28;

  // Base-128 grouping: up to five 7-bit groups per encoded value.
  localparam int GROUP_BITS = 7;
  localparam int MAX_GROUPS = 5;
  localparam int GRP_W      = GROUP_BITS * MAX_GROUPS;
  localparam int CNT_W      = $clog2(MAX_GROUPS + 1);

  // Arc accumulator product width (times ten plus one digit).
  localparam int MUL_W = ARC_BITS + 4;

  localparam int unsigned FIRST_SCALE   = 40;
  localparam int unsigned FIRST_ARC_MAX = 2;

  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_NINE = 8'h39;
  localparam logic [7:0] CHAR_DOT  = 8'h2E;

  localparam logic [7:0] MAX_BYTES_RESET = 8'd24;

  // Result status codes.
  localparam logic [1:0] STATUS_DATA   = 2'd0;
  localparam logic [1:0] STATUS_FINAL  = 2'd1;
  localparam logic [1:0] STATUS_REJECT = 2'd2;

  // Arc position within the OID.
  localparam logic [1:0] PH_FIRST  = 2'd0;
  localparam logic [1:0] PH_SECOND = 2'd1;
  localparam logic [1:0] PH_LATER  = 2'd2;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } oidber_in_t;

  typedef struct packed {
    logic [7:0] oid_byte;
    logic [1:0] status;
    logic       run_end;
  } oidber_out_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_CLOSE,
    S_SIZE,
    S_EMIT,
    S_REJ
  } oidber_state_t;

endpackage

>>> src/dotted_oid_to_ber_bytes_unit.sv
// Dotted OID text to BER content bytes: one character per item in, bytes out.
// The sequencer takes each character through IDLE and EVAL; the dot after the first arc
// also through CLOSE, a rejection through CLOSE (and SIZE) to REJ, and an arc of n bytes
// (1 to 5) through CLOSE, SIZE and EMIT. Arc bytes come out one per cycle from the single
// group selector while the output is free; a new character waits until the last is done.
// Reset (synchronous, rst_n low): max_bytes returns to 24 and the OID state rearms.
module dotted_oid_to_ber_bytes_unit (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  oidber_pkg::oidber_in_t   in_data,
  output logic                     out_valid,
  input  logic                     out_ready,
  output oidber_pkg::oidber_out_t  out_data,
  input  logic                     cfg_wr_en,
  input  logic [7:0]               cfg_wr_data
);
  import oidber_pkg::*;

  oidber_state_t         state_r, state_nxt;
  oidber_in_t            in_r, in_nxt;
  logic [1:0]            phase_r, phase_nxt;
  logic [1:0]            first_arc_r, first_arc_nxt;
  logic [ARC_BITS-1:0]   accum_r, accum_nxt;
  logic                  too_wide_r, too_wide_nxt;
  logic [7:0]            bytes_out_r, bytes_out_nxt;
  logic                  rejected_r, rejected_nxt;
  logic [7:0]            max_bytes_r;
  logic [GRP_W-1:0]      val_r, val_nxt;
  logic [CNT_W-1:0]      rem_r, rem_nxt;
  logic                  out_valid_r, out_valid_nxt;
  oidber_out_t           out_data_r, out_data_nxt;

  logic                  is_digit, is_dot, ends;
  logic [MUL_W-1:0]      acc_prod;
  logic                  acc_wide;
  logic [6:0]            first_scaled;
  logic [CNT_W-1:0]      grp_cnt;
  logic [8:0]            size_sum;
  logic                  too_long;
  logic [GROUP_BITS-1:0] grp_sel;
  logic                  out_free;
  logic                  do_rearm;

  // Character classification of the held item.
  assign is_digit = (in_r.ch >= CHAR_ZERO) && (in_r.ch <= CHAR_NINE);
  assign is_dot   = (in_r.ch == CHAR_DOT);
  assign ends     = in_r.last || (!is_digit && !is_dot);

  // Decimal accumulate: arc * 10 + digit, saturating at the arc width.
  assign acc_prod = (MUL_W'(accum_r) << 3) + (MUL_W'(accum_r) << 1)
                  + MUL_W'(in_r.ch[3:0]);
  assign acc_wide = |acc_prod[MUL_W-1:ARC_BITS];

  // First arc weight in the combined first value.
  assign first_scaled = 7'(first_arc_r * FIRST_SCALE);

  // Number of base-128 groups in the held value.
  always_comb begin
    grp_cnt = CNT_W'(1);
    for (int g = 1; g < MAX_GROUPS; g++) begin
      if (|val_r[g*GROUP_BITS +: GROUP_BITS]) begin
        grp_cnt = CNT_W'(g + 1);
      end
    end
  end

  // Length check against the configured limit.
  assign size_sum = {1'b0, bytes_out_r} + 9'(grp_cnt);
  assign too_long = size_sum > {1'b0, max_bytes_r};

  // Shared group selector: picks the group that is emitted next.
  always_comb begin
    grp_sel = '0;
    for (int g = 0; g < MAX_GROUPS; g++) begin
      if (rem_r == CNT_W'(g + 1)) begin
        grp_sel = val_r[g*GROUP_BITS +: GROUP_BITS];
      end
    end
  end

  assign out_free = !out_valid_r || out_ready;

  // Sequencer: next state and register updates.
  always_comb begin
    state_nxt     = state_r;
    in_nxt        = in_r;
    phase_nxt     = phase_r;
    first_arc_nxt = first_arc_r;
    accum_nxt     = accum_r;
    too_wide_nxt  = too_wide_r;
    bytes_out_nxt = bytes_out_r;
    rejected_nxt  = rejected_r;
    val_nxt       = val_r;
    rem_nxt       = rem_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    in_ready      = 1'b0;
    do_rearm      = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          in_nxt    = in_data;
          state_nxt = S_EVAL;
        end
      end

      S_EVAL: begin
        if (rejected_r) begin
          // Swallow characters until the one that ends the OID.
          do_rearm  = ends;
          state_nxt = S_IDLE;
        end else if (is_digit) begin
          accum_nxt    = acc_wide ? {ARC_BITS{1'b1}} : acc_prod[ARC_BITS-1:0];
          too_wide_nxt = too_wide_r || acc_wide;
          state_nxt    = in_r.last ? S_CLOSE : S_IDLE;
        end else begin
          state_nxt = S_CLOSE;
        end
      end

      S_CLOSE: begin
        if (phase_r == PH_FIRST) begin
          // The first arc must be small and closed by a dot.
          if (!is_dot || too_wide_r || (accum_r > ARC_BITS'(FIRST_ARC_MAX))) begin
            state_nxt = S_REJ;
          end else begin
            first_arc_nxt = accum_r[1:0];
            accum_nxt     = '0;
            phase_nxt     = PH_SECOND;
            val_nxt       = GRP_W'(7'(accum_r[1:0] * FIRST_SCALE));
            state_nxt     = in_r.last ? S_SIZE : S_IDLE;
          end
        end else if (too_wide_r) begin
          state_nxt = S_REJ;
        end else begin
          val_nxt = GRP_W'(accum_r)
                  + ((phase_r == PH_SECOND) ? GRP_W'(first_scaled) : GRP_W'(0));
          state_nxt = S_SIZE;
        end
      end

      S_SIZE: begin
        if (too_long) begin
          state_nxt = S_REJ;
        end else begin
          bytes_out_nxt = size_sum[7:0];
          rem_nxt       = grp_cnt;
          state_nxt     = S_EMIT;
        end
      end

      S_EMIT: begin
        if (out_free) begin
          out_valid_nxt         = 1'b1;
          out_data_nxt.oid_byte = {(rem_r != CNT_W'(1)), grp_sel};
          out_data_nxt.status   = ((rem_r == CNT_W'(1)) && ends) ? STATUS_FINAL
                                                                 : STATUS_DATA;
          out_data_nxt.run_end  = (rem_r == CNT_W'(1));
          rem_nxt               = rem_r - CNT_W'(1);
          if (rem_r == CNT_W'(1)) begin
            if (ends) begin
              do_rearm = 1'b1;
            end else begin
              phase_nxt = PH_LATER;
              accum_nxt = '0;
            end
            state_nxt = S_IDLE;
          end
        end
      end

      S_REJ: begin
        if (out_free) begin
          out_valid_nxt         = 1'b1;
          out_data_nxt.oid_byte = '0;
          out_data_nxt.status   = STATUS_REJECT;
          out_data_nxt.run_end  = 1'b1;
          if (ends) begin
            do_rearm = 1'b1;
          end else begin
            rejected_nxt = 1'b1;
          end
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // Start a fresh OID.
    if (do_rearm) begin
      phase_nxt     = PH_FIRST;
      first_arc_nxt = '0;
      accum_nxt     = '0;
      too_wide_nxt  = 1'b0;
      bytes_out_nxt = '0;
      rejected_nxt  = 1'b0;
    end
  end

  // Control and OID state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      phase_r     <= PH_FIRST;
      first_arc_r <= '0;
      accum_r     <= '0;
      too_wide_r  <= 1'b0;
      bytes_out_r <= '0;
      rejected_r  <= 1'b0;
      rem_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      first_arc_r <= first_arc_nxt;
      accum_r     <= accum_nxt;
      too_wide_r  <= too_wide_nxt;
      bytes_out_r <= bytes_out_nxt;
      rejected_r  <= rejected_nxt;
      rem_r       <= rem_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_bytes_r <= MAX_BYTES_RESET;
    end else if (cfg_wr_en) begin
      max_bytes_r <= cfg_wr_data;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    in_r       <= in_nxt;
    val_r      <= val_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

>>> src/oidber_checker.sv
// Port-level checker for the dotted OID to BER byte encoder, with its bind.
// Depends on oidber_pkg and dotted_oid_to_ber_bytes_unit_macros.svh.
`include "dotted_oid_to_ber_bytes_unit_macros.svh"

module oidber_checker (
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_valid,
  input logic                    in_ready,
  input logic                    out_valid,
  input logic                    out_ready,
  input oidber_pkg::oidber_out_t out_data
);
  import oidber_pkg::*;

  // A stalled result item holds its contents.
  `OIDBER_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "result item changed while stalled")

  // A rejection carries a zero byte and closes the run.
  `OIDBER_ASSERT_NOW(a_reject_form, out_valid && (out_data.status == STATUS_REJECT), (out_data.oid_byte == 8'd0) && out_data.run_end, "malformed rejection item")

  // Bytes inside an arc carry the continuation bit and plain data status.
  `OIDBER_ASSERT_NOW(a_cont_bit, out_valid && !out_data.run_end, out_data.oid_byte[7] && (out_data.status == STATUS_DATA), "inner arc byte without continuation bit")

  // The final byte of an arc never carries the continuation bit.
  `OIDBER_ASSERT_NOW(a_last_byte, out_valid && out_data.run_end && (out_data.status != STATUS_REJECT), !out_data.oid_byte[7], "closing arc byte with continuation bit")

  // The unit works on one character at a time.
  `OIDBER_ASSERT_NEXT(a_one_item, in_valid && in_ready, !in_ready, "second item accepted back to back")

endmodule

bind dotted_oid_to_ber_bytes_unit oidber_checker u_oidber_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

>>> verif/dotted_oid_to_ber_bytes_unit_chk.sv
// Checker for the dotted OID to BER byte encoder: predicts the encoded bytes of each item
// and compares them with the result channel. Depends on oidber_pkg for the item types.
module dotted_oid_to_ber_bytes_unit_chk (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  input  logic                     in_ready,
  input  oidber_pkg::oidber_in_t   in_data,
  input  logic                     out_valid,
  input  logic                     out_ready,
  input  oidber_pkg::oidber_out_t  out_data,
  input  logic                     cfg_wr_en,
  input  logic [7:0]               cfg_wr_data,
  output int                       mismatches,
  output int                       pending
);
  timeunit 1ns;
  timeprecision 1ps;

  import oidber_pkg::*;

  localparam logic [MUL_W-1:0] ARC_MAX = (MUL_W'(1) << ARC_BITS) - 1;

  // Encoder state as the block should hold it.
  logic [7:0]          max_len;
  logic [1:0]          arc_pos;
  logic [1:0]          lead_arc;
  logic [ARC_BITS-1:0] arc_value;
  logic                arc_overflow;
  logic [7:0]          emitted;
  logic                discard;

  // Encoded bytes still to come out of the block, oldest first.
  oidber_out_t ber_byte_q[$];
  int          result_idx;

  function automatic void rearm_oid();
    arc_pos      = PH_FIRST;
    lead_arc     = '0;
    arc_value    = '0;
    arc_overflow = 1'b0;
    emitted      = '0;
    discard      = 1'b0;
  endfunction

  function automatic void queue_result(logic [7:0] b, logic [1:0] st, logic e);
    oidber_out_t r;
    r.oid_byte = b;
    r.status   = st;
    r.run_end  = e;
    ber_byte_q.push_back(r);
  endfunction

  // A rejection writes one result; the OID rearms now or at its closing character.
  function automatic void reject_oid(logic closes);
    if (closes) begin
      rearm_oid();
    end else begin
      discard = 1'b1;
    end
    queue_result(8'h00, STATUS_REJECT, 1'b1);
  endfunction

  // Advance the encoder by one character and queue the bytes that it writes.
  function automatic void encode_oid_char(logic [7:0] c, logic fin);
    logic             is_digit;
    logic             is_dot;
    logic             closes;
    logic [MUL_W-1:0] acc;
    logic [34:0]      val;
    logic [6:0]       grp;
    int               n;
    int               i;
    is_digit = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
    is_dot   = (c == CHAR_DOT);
    closes   = fin || (!is_digit && !is_dot);

    // After a rejection, characters are dropped until the OID ends.
    if (discard) begin
      if (closes) rearm_oid();
      return;
    end

    // Digits accumulate into the open arc, saturating when it gets too wide.
    if (is_digit) begin
      acc = MUL_W'(arc_value) * MUL_W'(10) + MUL_W'(c - CHAR_ZERO);
      if (acc > ARC_MAX) begin
        arc_overflow = 1'b1;
        acc = ARC_MAX;
      end
      arc_value = acc[ARC_BITS-1:0];
      if (!fin) return;
    end

    // The first arc must be 0 to 2 and be closed by a dot.
    if (arc_pos == PH_FIRST) begin
      if (!is_dot || arc_overflow || arc_value > FIRST_ARC_MAX) begin
        reject_oid(closes);
        return;
      end
      lead_arc  = arc_value[1:0];
      arc_value = '0;
      arc_pos   = PH_SECOND;
      if (!fin) return;
    end

    if (arc_overflow) begin
      reject_oid(closes);
      return;
    end

    val = 35'(arc_value);
    if (arc_pos == PH_SECOND) val = val + 35'(lead_arc) * 35'(FIRST_SCALE);

    n = 1;
    while (n < MAX_GROUPS && (val >> (GROUP_BITS * n)) != 0) n++;

    if (int'(emitted) + n > int'(max_len)) begin
      reject_oid(closes);
      return;
    end
    emitted = emitted + 8'(n);

    // Base-128, most significant group first, continuation bit on all but the last.
    for (i = 0; i < n; i++) begin
      grp = 7'(val >> (GROUP_BITS * (n - 1 - i)));
      queue_result({(i + 1 < n), grp},
                   (i + 1 == n && closes) ? STATUS_FINAL : STATUS_DATA,
                   i + 1 == n);
    end

    if (closes) begin
      rearm_oid();
    end else begin
      arc_pos   = PH_LATER;
      arc_value = '0;
    end
  endfunction

  // Results are checked before new items are predicted: no item can come out at the
  // edge that accepts it.
  always @(posedge clk) begin
    oidber_out_t exp_r;
    if (!rst_n) begin
      max_len = MAX_BYTES_RESET;
      rearm_oid();
      ber_byte_q.delete();
      result_idx = 0;
      mismatches = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (ber_byte_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected result %0d: byte=%h status=%0d end=%0b", $time,
                     result_idx, out_data.oid_byte, out_data.status, out_data.run_end);
        end else begin
          exp_r = ber_byte_q.pop_front();
          if (out_data !== exp_r) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"%0t: result %0d: expected byte=%h status=%0d end=%0b,",
                        " got byte=%h status=%0d end=%0b"},
                       $time, result_idx, exp_r.oid_byte, exp_r.status, exp_r.run_end,
                       out_data.oid_byte, out_data.status, out_data.run_end);
          end
        end
        result_idx++;
      end
      if (cfg_wr_en) max_len = cfg_wr_data;
      if (in_valid && in_ready) encode_oid_char(in_data.ch, in_data.last);
    end
    pending = ber_byte_q.size();
  end

endmodule

>>> verif/dotted_oid_to_ber_bytes_unit_tb.sv
// Testbench top for the dotted OID to BER byte encoder: drives OID text and register
// settings, and gives the verdict. Depends on oidber_pkg and dotted_oid_to_ber_bytes_unit_chk.
module dotted_oid_to_ber_bytes_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import oidber_pkg::*;

  localparam int QUIET_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 16;
  localparam int PHASE_ITEMS = 60;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  oidber_in_t  in_data;
  logic        out_valid;
  logic        out_ready;
  oidber_out_t out_data;
  logic        cfg_wr_en;
  logic [7:0]  cfg_wr_data;
  int          mismatches;
  int          pending;

  int          burst_left;
  bit          gaps_on;
  int          chars_sent;
  int          quiet_cycles;

  dotted_oid_to_ber_bytes_unit DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  dotted_oid_to_ber_bytes_unit_chk u_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .mismatches  (mismatches),
    .pending     (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: too long without any accepted item ends the run.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("dotted_oid_to_ber_bytes_unit: mismatch");
      $finish;
    end
  end

  // Receiver stalls in windows of changing character: always ready, coin flips,
  // a fixed pattern, and long mostly-stalled stretches.
  initial begin
    int mode;
    int span;
    int k;
    out_ready = 1'b0;
    k = 0;
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(16, 96);
      repeat (span) begin
        @(negedge clk);
        k++;
        case (mode)
          0: begin
            out_ready <= 1'b1;
          end
          1: begin
            out_ready <= 1'($urandom_range(0, 1));
          end
          2: begin
            out_ready <= (k % 4) != 3;
          end
          default: begin
            out_ready <= (k % 5) == 0;
          end
        endcase
      end
    end
  end

  // Send one character, with a random gap when a burst runs out and gaps are on.
  task automatic send_char(input logic [7:0] c, input logic fin);
    oidber_in_t item;
    int g;
    if (burst_left == 0) begin
      if (gaps_on) begin
        g = $urandom_range(1, 12);
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (g - 1) @(negedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    item.ch   = c;
    item.last = fin;
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
    chars_sent++;
  endtask

  task automatic send_text(input string s, input logic fin_on_end);
    int j;
    for (j = 0; j < s.len(); j++) send_char(s[j], fin_on_end && (j == s.len() - 1));
  endtask

  // Stop sending and wait until every expected byte is out and the block is quiet.
  task automatic drain_block();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_max_bytes(input logic [7:0] v);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // Append one decimal arc: mostly short, sometimes empty, sometimes at the width limit.
  task automatic append_arc(ref logic [7:0] txt[$]);
    string near_max;
    int pick;
    int ndig;
    int j;
    pick = $urandom_range(0, 9);
    if (pick == 0) begin
      ndig = 0;
    end else if (pick <= 6) begin
      ndig = $urandom_range(1, 3);
    end else if (pick <= 8) begin
      ndig = $urandom_range(4, 8);
    end else begin
      ndig = $urandom_range(9, 10);
    end
    if (pick == 9 && $urandom_range(0, 1) == 1) begin
      near_max = ($urandom_range(0, 1) == 1) ? "268435455" : "268435456";
      for (j = 0; j < near_max.len(); j++) txt.push_back(near_max[j]);
    end else begin
      repeat (ndig) txt.push_back(CHAR_ZERO + 8'($urandom_range(0, 9)));
    end
  endtask

  // One OID: mostly well formed with random arcs and endings, the rest line noise.
  task automatic send_random_oid();
    logic [7:0] txt[$];
    logic [7:0] term;
    logic       term_last;
    int         pick;
    int         narcs;
    int         k;
    pick = $urandom_range(0, 9);
    if (pick < 2) begin
      narcs = $urandom_range(1, 8);
      repeat (narcs) txt.push_back(8'($urandom_range(0, 255)));
      for (k = 0; k < txt.size(); k++)
        send_char(txt[k], (k == txt.size() - 1) ? 1'b1 : 1'($urandom_range(0, 1)));
      return;
    end

    // First arc: usually legal, sometimes an arbitrary digit run.
    if ($urandom_range(0, 7) == 0) begin
      append_arc(txt);
    end else begin
      txt.push_back(CHAR_ZERO + 8'($urandom_range(0, 2)));
    end
    txt.push_back(CHAR_DOT);
    narcs = $urandom_range(1, 6);
    for (k = 0; k < narcs; k++) begin
      if (k > 0) txt.push_back(CHAR_DOT);
      append_arc(txt);
    end

    // Ending: last on a digit, a trailing dot, or a terminator character.
    pick = $urandom_range(0, 3);
    term_last = 1'b1;
    if (pick == 1) begin
      txt.push_back(CHAR_DOT);
    end else if (pick >= 2) begin
      do term = 8'($urandom_range(0, 255));
      while ((term >= CHAR_ZERO && term <= CHAR_NINE) || term == CHAR_DOT);
      txt.push_back(term);
      term_last = (pick == 2) ? 1'($urandom_range(0, 1)) : 1'b0;
    end else if (txt[txt.size() - 1] == CHAR_DOT) begin
      txt.push_back(CHAR_ZERO + 8'($urandom_range(0, 9)));
    end
    for (k = 0; k < txt.size() - 1; k++) send_char(txt[k], 1'b0);
    send_char(txt[txt.size() - 1], term_last);
  endtask

  // Main stimulus.
  initial begin
    logic [7:0] settings[8];
    int ph;
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_data     = '0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    burst_left  = 0;
    gaps_on     = 1'b1;
    chars_sent  = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed cases at the reset limit.
    send_text("1.3", 1'b1);
    // Dot on the last character closes the combined first value alone.
    send_text("2.", 1'b1);
    // Empty first arc reads as zero.
    send_text(".5", 1'b1);
    // Widest legal second arc: five bytes.
    send_text("2.268435455", 1'b1);
    // Bad first arc, then the rest of the OID is dropped.
    send_text("3.7", 1'b1);
    // OID ends before its first dot.
    send_text("1", 1'b1);
    // Non-digit terminator without the last flag.
    send_text("1.2", 1'b0);
    send_char(8'hFF, 1'b0);
    // Empty final arc closed by a terminator with the last flag.
    send_text("0.9.", 1'b0);
    send_char(8'h00, 1'b1);
    drain_block();

    // Random phases, each under its own byte limit; extremes and out-of-range values too.
    settings[0] = 8'd255;
    settings[1] = 8'd2;
    settings[2] = 8'd0;
    settings[3] = 8'd5;
    settings[4] = 8'd1;
    settings[5] = 8'($urandom_range(2, 255));
    settings[6] = MAX_BYTES_RESET;
    settings[7] = 8'($urandom_range(0, 255));
    for (ph = 0; ph < 8; ph++) begin
      write_max_bytes(settings[ph]);
      gaps_on = (ph != 3) && (ph != 6);
      burst_left = 0;
      while (chars_sent < 31 + (ph + 1) * PHASE_ITEMS) send_random_oid();
      drain_block();
    end

    if (mismatches == 0 && pending == 0) begin
      $display("dotted_oid_to_ber_bytes_unit: match");
    end else begin
      $display("dotted_oid_to_ber_bytes_unit: mismatch");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+src
src/oidber_pkg.sv
src/dotted_oid_to_ber_bytes_unit.sv
src/oidber_checker.sv
verif/dotted_oid_to_ber_bytes_unit_chk.sv
verif/dotted_oid_to_ber_bytes_unit_tb.sv
